// ===== src/wec_pkg.sv =====
// Shared types and constants for the wealth exchange step core
package wec_pkg;

   localparam int INDEX_BITS = 10;
   localparam int FRAC_BITS = 20;
   localparam int A_BITS = 16;
   localparam int LOG_FRAC = 16;
   localparam int LOG_W = 22;
   localparam int X_W = 41;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_REG_EXPONENT = 1'b0;
   localparam logic [A_BITS-1:0] EXPONENT_RESET = 16'd4096;

   typedef struct packed {
      logic accept;
      logic rd_u;
      logic rd_v;
      logic get_v;
      logic check;
      logic log_start;
      logic log_sel_e;
      logic x_calc;
      logic mul_lo;
      logic mul_hi;
      logic new_w;
      logic wr_u;
      logic wr_v;
      logic clr_wr;
      logic out_load;
   } wec_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic do_exch;
      logic equal;
      logic log_done;
      logic x_nonneg;
      logic e_zero;
      logic le_lt_x;
   } wec_status_type;

endpackage

// ===== src/wealth_exchange_monte_carlo_step_core.sv =====
// Top level of the kinetic wealth exchange Metropolis step core
// Usage: each item on req_ names two agents and a share e (Q0.SHARE_BITS).
// The core reads both Q12.20 wealths, decides acceptance with p = 2*|u-v|^-a
// (a from the APB register at byte address 0, Q4.12, reset 1.0), splits the
// pair total when accepted, and returns one item on rsp_ with the acceptance
// flag and both wealths after the step.
// An out-of-range or same-agent pair and a pair of equal wealths skip log2;
// other pairs take one or two log2 passes. Each pass is a normalize phase
// plus a squaring phase for 16 fraction bits in the single shared log2 unit.
// One item is in flight at a time.
// Reset: the wealth memory is swept to 1.0, one entry per cycle, over
// min(NUM_AGENTS,1024) entries; req_ready stays low until it completes.
// Stall: a finished result waits in the output register; the next item is
// taken meanwhile and holds in its last step until the register frees.
module wealth_exchange_monte_carlo_step_core import wec_pkg::*; #(
   parameter int NUM_AGENTS = 1024,
   parameter int WEALTH_BITS = 32,
   parameter int SHARE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [INDEX_BITS-1:0]  req_agent_first,
   input  logic [INDEX_BITS-1:0]  req_agent_second,
   input  logic [SHARE_BITS-1:0]  req_share,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic [WEALTH_BITS-1:0] rsp_wealth_first,
   output logic [WEALTH_BITS-1:0] rsp_wealth_second,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [A_BITS-1:0] exponent_ff;
   wec_cmd_type       cmd;
   wec_status_type    status;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_REG_EXPONENT) ? 32'(exponent_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXPONENT_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_REG_EXPONENT)) begin
         exponent_ff <= pwdata[A_BITS-1:0];
      end
   end

   wec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wec_datapath #(
      .NUM_AGENTS  (NUM_AGENTS),
      .WEALTH_BITS (WEALTH_BITS),
      .SHARE_BITS  (SHARE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .exponent_a        (exponent_ff),
      .agent_first       (req_agent_first),
      .agent_second      (req_agent_second),
      .share             (req_share),
      .out_accepted      (rsp_accepted),
      .out_wealth_first  (rsp_wealth_first),
      .out_wealth_second (rsp_wealth_second)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while another is in flight");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_u, cmd.wr_v, cmd.clr_wr}))
      else $error("memory write port conflict");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result shown without output load");

endmodule

// ===== src/wec_log2.sv =====
// Iterative fixed-point log2 unit: normalize, then one fraction bit per squaring
module wec_log2 import wec_pkg::*; #(
   parameter int LW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LW-1:0]    m,
   output logic             done,
   output logic [LOG_W-1:0] result
);

   localparam int KW = $clog2(LW);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_NORM = 3'b010,
      L_SQ   = 3'b100
   } log_state_type;

   log_state_type     state_ff, state_in;
   logic [LW-1:0]     n_ff, n_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [31:0]       mant_ff, mant_in;
   logic [15:0]       frac_ff, frac_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [63:0]       ext;
   logic [63:0]       sq_full;
   logic [32:0]       sq;

   always_comb begin
      ext = 64'(n_ff) << (64 - LW);
      sq_full = 64'(mant_ff) * 64'(mant_ff);
      sq = 33'(sq_full >> 31);
      state_in = state_ff;
      n_in = n_ff;
      k_in = k_ff;
      mant_in = mant_ff;
      frac_in = frac_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               n_in = m;
               k_in = KW'(LW - 1);
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            priority if (n_ff[LW-1]) begin
               mant_in = ext[63:32];
               frac_in = '0;
               cnt_in = '0;
               state_in = L_SQ;
            end else if (n_ff[LW-1 -: 8] == 8'd0) begin
               n_in = n_ff << 8;
               k_in = k_ff - KW'(8);
            end else begin
               n_in = n_ff << 1;
               k_in = k_ff - KW'(1);
            end
         end
         L_SQ: begin
            if (sq[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               mant_in = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               mant_in = sq[31:0];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               done_in = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      k_ff <= k_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign result = LOG_W'({k_ff, frac_ff});

endmodule

// ===== src/wec_datapath.sv =====
// Datapath: wealth memory, acceptance arithmetic, split multiply, result register
module wec_datapath import wec_pkg::*; #(
   parameter int NUM_AGENTS = 1024,
   parameter int WEALTH_BITS = 32,
   parameter int SHARE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wec_cmd_type            cmd,
   output wec_status_type         status,
   input  logic [A_BITS-1:0]      exponent_a,
   input  logic [INDEX_BITS-1:0]  agent_first,
   input  logic [INDEX_BITS-1:0]  agent_second,
   input  logic [SHARE_BITS-1:0]  share,
   output logic                   out_accepted,
   output logic [WEALTH_BITS-1:0] out_wealth_first,
   output logic [WEALTH_BITS-1:0] out_wealth_second
);

   localparam int DEPTH = (NUM_AGENTS < 1024) ? NUM_AGENTS : 1024;
   localparam int AW = $clog2(DEPTH);
   localparam int LW = (WEALTH_BITS > SHARE_BITS) ? WEALTH_BITS : SHARE_BITS;
   localparam logic [WEALTH_BITS-1:0] WEALTH_ONE = (WEALTH_BITS > FRAC_BITS) ?
      WEALTH_BITS'(64'd1 << FRAC_BITS) : {WEALTH_BITS{1'b1}};

   logic [WEALTH_BITS-1:0] wealth_mem [DEPTH];
   logic [WEALTH_BITS-1:0] rdata_ff;
   logic [AW-1:0]          clr_cnt_ff;
   logic [INDEX_BITS-1:0]  iu_ff, iv_ff;
   logic [SHARE_BITS-1:0]  e_ff;
   logic                   ok_u, ok_v;
   logic [WEALTH_BITS-1:0] wu_ff, wv_ff, s_ff;
   logic [WEALTH_BITS:0]   sum;
   logic [WEALTH_BITS-1:0] d;
   logic                   acc_ff;
   logic [63:0]            prod_lo_ff, prod_hi_ff;
   logic [63:0]            s_pad;
   logic [95:0]            total;
   logic [WEALTH_BITS-1:0] nu;
   logic signed [X_W-1:0]  x_ff, ld_s, le_s;
   logic                   log_done;
   logic [LOG_W-1:0]       log_res;
   logic [LW-1:0]          log_m;
   logic                   rsp_acc_ff;
   logic [WEALTH_BITS-1:0] rsp_wf_ff, rsp_ws_ff;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [WEALTH_BITS-1:0] wr_data;
   logic                   wr_en;

   assign ok_u = 17'(iu_ff) < 17'(NUM_AGENTS);
   assign ok_v = 17'(iv_ff) < 17'(NUM_AGENTS);
   assign sum = {1'b0, wu_ff} + {1'b0, wv_ff};
   assign d = (wu_ff > wv_ff) ? (wu_ff - wv_ff) : (wv_ff - wu_ff);
   assign s_pad = 64'(s_ff);
   assign total = {prod_hi_ff, 32'd0} + {32'd0, prod_lo_ff};
   assign nu = WEALTH_BITS'(total >> SHARE_BITS);
   assign log_m = cmd.log_sel_e ? LW'(e_ff) : LW'(d);
   assign ld_s = $signed(X_W'(log_res)) - $signed(X_W'(FRAC_BITS << LOG_FRAC));
   assign le_s = ($signed(X_W'(log_res)) - $signed(X_W'(SHARE_BITS << LOG_FRAC))) <<< 12;

   wec_log2 #(.LW(LW)) u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .m      (log_m),
      .done   (log_done),
      .result (log_res)
   );

   always_comb begin
      wr_en = cmd.clr_wr | cmd.wr_u | cmd.wr_v;
      priority if (cmd.clr_wr) begin
         wr_addr = clr_cnt_ff;
         wr_data = WEALTH_ONE;
      end else if (cmd.wr_u) begin
         wr_addr = iu_ff[AW-1:0];
         wr_data = wu_ff;
      end else begin
         wr_addr = iv_ff[AW-1:0];
         wr_data = wv_ff;
      end
      rd_addr = cmd.rd_v ? iv_ff[AW-1:0] : iu_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wealth_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= wealth_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         iu_ff <= agent_first;
         iv_ff <= agent_second;
         e_ff <= share;
         acc_ff <= 1'b0;
      end
      if (cmd.rd_v) begin
         wu_ff <= ok_u ? rdata_ff : '0;
      end
      if (cmd.get_v) begin
         wv_ff <= ok_v ? rdata_ff : '0;
      end
      if (cmd.check) begin
         s_ff <= sum[WEALTH_BITS] ? {WEALTH_BITS{1'b1}} : sum[WEALTH_BITS-1:0];
      end
      if (cmd.x_calc) begin
         x_ff <= $signed(X_W'(64'd1 << 28)) - ($signed({1'b0, exponent_a}) * ld_s);
      end
      if (cmd.mul_lo) begin
         prod_lo_ff <= 64'(32'(e_ff)) * 64'(s_pad[31:0]);
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= 64'(32'(e_ff)) * 64'(s_pad[63:32]);
      end
      if (cmd.new_w) begin
         wu_ff <= nu;
         wv_ff <= s_ff - nu;
         acc_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_acc_ff <= acc_ff;
         rsp_wf_ff <= wu_ff;
         rsp_ws_ff <= wv_ff;
      end
   end

   assign status.clear_last = (clr_cnt_ff == AW'(DEPTH - 1));
   assign status.do_exch = ok_u & ok_v & (iu_ff != iv_ff);
   assign status.equal = (wu_ff == wv_ff);
   assign status.log_done = log_done;
   assign status.x_nonneg = ~x_ff[X_W-1];
   assign status.e_zero = (e_ff == '0);
   assign status.le_lt_x = (le_s < x_ff);

   assign out_accepted = rsp_acc_ff;
   assign out_wealth_first = rsp_wf_ff;
   assign out_wealth_second = rsp_ws_ff;

endmodule

// ===== src/wec_ctrl.sv =====
// Controller state machine sequencing memory access, log2 steps and the split
module wec_ctrl import wec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  wec_status_type status,
   output wec_cmd_type    cmd
);

   typedef enum logic [16:0] {
      S_CLEAR   = 17'b00000000000000001,
      S_IDLE    = 17'b00000000000000010,
      S_RD_U    = 17'b00000000000000100,
      S_RD_V    = 17'b00000000000001000,
      S_GET_V   = 17'b00000000000010000,
      S_CHECK   = 17'b00000000000100000,
      S_LOG_D   = 17'b00000000001000000,
      S_X       = 17'b00000000010000000,
      S_X_CHECK = 17'b00000000100000000,
      S_LOG_E   = 17'b00000001000000000,
      S_E_CHECK = 17'b00000010000000000,
      S_MUL_LO  = 17'b00000100000000000,
      S_MUL_HI  = 17'b00001000000000000,
      S_NEW     = 17'b00010000000000000,
      S_WR_U    = 17'b00100000000000000,
      S_WR_V    = 17'b01000000000000000,
      S_OUT     = 17'b10000000000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_RD_U;
            end
         end
         S_RD_U: begin
            cmd.rd_u = 1'b1;
            state_in = S_RD_V;
         end
         S_RD_V: begin
            cmd.rd_v = 1'b1;
            state_in = S_GET_V;
         end
         S_GET_V: begin
            cmd.get_v = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            priority if (!status.do_exch) begin
               state_in = S_OUT;
            end else if (status.equal) begin
               state_in = S_MUL_LO;
            end else begin
               cmd.log_start = 1'b1;
               state_in = S_LOG_D;
            end
         end
         S_LOG_D: begin
            if (status.log_done) begin
               state_in = S_X;
            end
         end
         S_X: begin
            cmd.x_calc = 1'b1;
            state_in = S_X_CHECK;
         end
         S_X_CHECK: begin
            if (status.x_nonneg || status.e_zero) begin
               state_in = S_MUL_LO;
            end else begin
               cmd.log_start = 1'b1;
               cmd.log_sel_e = 1'b1;
               state_in = S_LOG_E;
            end
         end
         S_LOG_E: begin
            if (status.log_done) begin
               state_in = S_E_CHECK;
            end
         end
         S_E_CHECK: begin
            state_in = status.le_lt_x ? S_MUL_LO : S_OUT;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in = S_NEW;
         end
         S_NEW: begin
            cmd.new_w = 1'b1;
            state_in = S_WR_U;
         end
         S_WR_U: begin
            cmd.wr_u = 1'b1;
            state_in = S_WR_V;
         end
         S_WR_V: begin
            cmd.wr_v = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
